// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the tile locator.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(name, clk_s, rstn_s, prop) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("assertion failed");

// when ante holds, cons must hold at the same edge
`define ASSERT_IMPLY(name, clk_s, rstn_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(name, clk_s, rstn_s, prop)
`define ASSERT_IMPLY(name, clk_s, rstn_s, ante, cons)

`endif

`endif

// ----- hdl/ftl_pkg.sv -----
// Types and constants of the fragment tile locator.
// No dependencies; used by ftl_place, the top level and the testbench.
package ftl_pkg;

  localparam int SIDE_W    = 13;   // tile and region sides
  localparam int MAX_SIDE  = 4096;
  localparam int NUM_W     = 24;   // tile number
  localparam int REG16_W   = 16;
  localparam int ADDR_W    = 32;
  localparam int POS_W     = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 32;
  localparam int DIV_STEPS = 4;    // divider steps per pipeline stage

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_SIZE     = 3'd0,
    CFG_REGION_WIDTH  = 3'd1,
    CFG_REGION_HEIGHT = 3'd2,
    CFG_REGION_X      = 3'd3,
    CFG_REGION_Y      = 3'd4,
    CFG_ROW_PITCH     = 3'd5,
    CFG_ROW_STRIDE    = 3'd6,
    CFG_BASE_ADDRESS  = 3'd7
  } cfg_idx_t;

  // configuration, sides already clamped to MAX_SIDE
  typedef struct packed {
    logic [SIDE_W-1:0]  side;
    logic [SIDE_W-1:0]  wid;
    logic [SIDE_W-1:0]  hgt;
    logic [REG16_W-1:0] rx;
    logic [REG16_W-1:0] ry;
    logic [REG16_W-1:0] pitch;
    logic [REG16_W-1:0] stride;
    logic [ADDR_W-1:0]  base;
  } cfg_t;

  // sideband through the row/column divider
  typedef struct packed {
    logic             tile_ok;
    logic [NUM_W-1:0] number;
  } loc_side_t;

  // located item handed to the placement stages
  typedef struct packed {
    logic              vld;
    logic              tile_ok;
    logic [NUM_W-1:0]  number;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
  } loc_t;

  // one result item
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] address;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [SIDE_W-1:0] width;
    logic [SIDE_W-1:0] height;
    logic [POS_W-1:0]  stride;
    logic [NUM_W-1:0]  number;
  } res_t;

  // clamp a side register to MAX_SIDE
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    logic [SIDE_W-1:0] lim;
    lim = SIDE_W'(MAX_SIDE);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// ----- hdl/ftl_div_pipe.sv -----
// Pipelined restoring divider, at most SPS quotient bits per stage, with sideband.
// Depends on nothing; instantiated by the top level of the tile locator.
// The dividend must satisfy dividend >> QW < divisor for a correct result.
module ftl_div_pipe #(
  parameter int DW  = 24,
  parameter int VW  = 13,
  parameter int QW  = 13,
  parameter int SPS = 4,
  parameter int SW  = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_vld,
  input  logic [DW-1:0] in_dividend,
  input  logic [VW-1:0] in_divisor,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [VW-1:0] out_rem,
  output logic [SW-1:0] out_side
);

  localparam int NS = (QW + SPS - 1) / SPS;

  logic          vld_w  [NS+1];
  logic [VW-1:0] rem_w  [NS+1];
  logic [QW-1:0] lo_w   [NS+1];
  logic [VW-1:0] dvs_w  [NS+1];
  logic [SW-1:0] side_w [NS+1];

  // stage 0 input: upper dividend bits seed the partial remainder
  assign vld_w[0]  = in_vld;
  assign rem_w[0]  = VW'(in_dividend >> QW);
  assign lo_w[0]   = in_dividend[QW-1:0];
  assign dvs_w[0]  = in_divisor;
  assign side_w[0] = in_side;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam int NSTEP = ((QW - g*SPS) < SPS) ? (QW - g*SPS) : SPS;

    logic          vld_r;
    logic [VW-1:0] rem_r, rem_nxt;
    logic [QW-1:0] lo_r, lo_nxt;
    logic [VW-1:0] dvs_r;
    logic [SW-1:0] side_r;

    // shift in one dividend bit, subtract when it fits, shift in the quotient bit
    always_comb begin
      logic [VW:0] trial;
      rem_nxt = rem_w[g];
      lo_nxt  = lo_w[g];
      trial   = '0;
      for (int k = 0; k < NSTEP; k++) begin
        trial = {rem_nxt, lo_nxt[QW-1]};
        if (trial >= {1'b0, dvs_w[g]}) begin
          trial  = trial - {1'b0, dvs_w[g]};
          lo_nxt = {lo_nxt[QW-2:0], 1'b1};
        end else begin
          lo_nxt = {lo_nxt[QW-2:0], 1'b0};
        end
        rem_nxt = trial[VW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld_w[g];
      end
    end

    always_ff @(posedge clk) begin
      rem_r  <= rem_nxt;
      lo_r   <= lo_nxt;
      dvs_r  <= dvs_w[g];
      side_r <= side_w[g];
    end

    assign vld_w[g+1]  = vld_r;
    assign rem_w[g+1]  = rem_r;
    assign lo_w[g+1]   = lo_r;
    assign dvs_w[g+1]  = dvs_r;
    assign side_w[g+1] = side_r;
  end

  assign out_vld  = vld_w[NS];
  assign out_quo  = lo_w[NS];
  assign out_rem  = rem_w[NS];
  assign out_side = side_w[NS];

endmodule

// ----- hdl/ftl_place.sv -----
// Placement stages: tile offsets, clipped size, address and stride.
// Depends on ftl_pkg; instantiated by fragment_tile_locator_unit.
module ftl_place (
  input  logic          clk,
  input  logic          rst_n,
  input  ftl_pkg::cfg_t cfg,
  input  ftl_pkg::loc_t loc,
  output logic          res_strobe,
  output ftl_pkg::res_t res
);

  localparam int SW  = ftl_pkg::SIDE_W;
  localparam int RW  = ftl_pkg::REG16_W;
  localparam int AW  = ftl_pkg::ADDR_W;
  localparam int PW  = ftl_pkg::POS_W;
  localparam int NW  = ftl_pkg::NUM_W;
  localparam int MW  = SW + RW;     // yoff * pitch

  // ---- stage X: offsets of the tile inside the region
  logic            x_vld_r;
  logic            x_ok_r;
  logic [NW-1:0]   x_num_r;
  logic [SW-1:0]   x_xoff_r, x_yoff_r;
  logic [2*SW-1:0] xprod_nxt, yprod_nxt;

  assign xprod_nxt = {{SW{1'b0}}, loc.col} * {{SW{1'b0}}, cfg.side};
  assign yprod_nxt = {{SW{1'b0}}, loc.row} * {{SW{1'b0}}, cfg.side};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
    end else begin
      x_vld_r <= loc.vld;
    end
  end

  // offsets are below the region side for a real tile
  always_ff @(posedge clk) begin
    x_ok_r   <= loc.tile_ok;
    x_num_r  <= loc.number;
    x_xoff_r <= xprod_nxt[SW-1:0];
    x_yoff_r <= yprod_nxt[SW-1:0];
  end

  // ---- stage Y: pitch product, clipped size, frame position
  logic          y_vld_r;
  logic          y_ok_r;
  logic [NW-1:0] y_num_r;
  logic [SW-1:0] y_xoff_r;
  logic [MW-1:0] y_prod_r, prod_nxt;
  logic [SW-1:0] y_tw_r, y_th_r, tw_nxt, th_nxt, wleft, hleft;
  logic [PW-1:0] y_tx_r, y_ty_r;

  assign prod_nxt = {{RW{1'b0}}, x_yoff_r} * {{SW{1'b0}}, cfg.pitch};
  assign wleft    = cfg.wid - x_xoff_r;
  assign hleft    = cfg.hgt - x_yoff_r;
  assign tw_nxt   = (wleft > cfg.side) ? cfg.side : wleft;
  assign th_nxt   = (hleft > cfg.side) ? cfg.side : hleft;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      y_vld_r <= 1'b0;
    end else begin
      y_vld_r <= x_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    y_ok_r   <= x_ok_r;
    y_num_r  <= x_num_r;
    y_xoff_r <= x_xoff_r;
    y_prod_r <= prod_nxt;
    y_tw_r   <= tw_nxt;
    y_th_r   <= th_nxt;
    y_tx_r   <= {1'b0, cfg.rx} + {{(PW-SW){1'b0}}, x_xoff_r};
    y_ty_r   <= {1'b0, cfg.ry} + {{(PW-SW){1'b0}}, x_yoff_r};
  end

  // ---- stage Z: address, stride, zero fields of a missing tile
  logic            res_strobe_r;
  ftl_pkg::res_t   res_r, res_nxt;
  logic [SW-1:0]   wrest;
  logic [AW-1:0]   addr_nxt;
  logic [PW-1:0]   stride_nxt;

  assign wrest      = cfg.wid - y_tw_r;
  assign addr_nxt   = cfg.base + {{(AW-MW){1'b0}}, y_prod_r}
                    + {{(AW-SW-2){1'b0}}, y_xoff_r, 2'b00};
  assign stride_nxt = {1'b0, cfg.stride} + {{(PW-SW-2){1'b0}}, wrest, 2'b00};

  always_comb begin
    res_nxt        = '0;
    res_nxt.number = y_num_r;
    if (y_ok_r) begin
      res_nxt.valid   = 1'b1;
      res_nxt.address = addr_nxt;
      res_nxt.x       = y_tx_r;
      res_nxt.y       = y_ty_r;
      res_nxt.width   = y_tw_r;
      res_nxt.height  = y_th_r;
      res_nxt.stride  = stride_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_strobe_r <= 1'b0;
    end else begin
      res_strobe_r <= y_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_strobe = res_strobe_r;
  assign res        = res_r;

endmodule

// ----- hdl/fragment_tile_locator_unit.sv -----
// Fragment tile locator: finds a square tile inside a rectangular pixel region.
// Depends on ftl_pkg, ftl_div_pipe, ftl_place and assert_macros.svh.
//
// Usage:
//   Configuration: set cfg_we with cfg_index and cfg_wdata; the register is
//   written at that clock edge. Write only while no item is in flight.
//   Input: an item (in_tile_number) is taken at each edge where start is high
//   and busy is low. busy is set during reset and cleared at the first edge with rst_n high.
//   Output: out_strobe marks each result for one cycle; every item gives one
//   result, in order. The result sink cannot stall the block.
//   Pipeline: an accepted item passes 13 register stages before out_strobe:
//   input, 4 stages of tiles-per-row/column division, tile count product,
//   4 stages of row/column division, then offsets, size/pitch product and
//   address sum.
//   Throughput: one item per cycle while busy is low; each divider retires up to
//   4 quotient bits per stage so every stage takes a new item every clock.
//   Reset: synchronous, active low; clears all valid bits and sets the
//   registers to tile size 64 and everything else 0.
module fragment_tile_locator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] in_tile_number,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_strobe,
  output logic        out_tile_valid,
  output logic [31:0] out_tile_address,
  output logic [16:0] out_tile_x,
  output logic [16:0] out_tile_y,
  output logic [12:0] out_tile_width,
  output logic [12:0] out_tile_height,
  output logic [16:0] out_tile_stride,
  output logic [23:0] out_echo_number
);

`include "assert_macros.svh"

  localparam int SW       = ftl_pkg::SIDE_W;
  localparam int NW       = ftl_pkg::NUM_W;
  localparam int TW       = 2 * SW;                 // tile count width
  localparam int STEPS    = ftl_pkg::DIV_STEPS;
  localparam int DIV_STG  = (SW + STEPS - 1) / STEPS;
  localparam int PIPE_REGS = 2 + 2 * DIV_STG + 3;
  localparam int LSW      = $bits(ftl_pkg::loc_side_t);

  // ---- configuration registers
  ftl_pkg::cfg_t cfg_r;

  // side is the leading field: tile size 64, everything else 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= {SW'(64), {($bits(ftl_pkg::cfg_t) - SW){1'b0}}};
    end else if (cfg_we) begin
      unique case (ftl_pkg::cfg_idx_t'(cfg_index))
        ftl_pkg::CFG_TILE_SIZE:     cfg_r.side   <= ftl_pkg::clamp_side(cfg_wdata[SW-1:0]);
        ftl_pkg::CFG_REGION_WIDTH:  cfg_r.wid    <= ftl_pkg::clamp_side(cfg_wdata[SW-1:0]);
        ftl_pkg::CFG_REGION_HEIGHT: cfg_r.hgt    <= ftl_pkg::clamp_side(cfg_wdata[SW-1:0]);
        ftl_pkg::CFG_REGION_X:      cfg_r.rx     <= cfg_wdata[15:0];
        ftl_pkg::CFG_REGION_Y:      cfg_r.ry     <= cfg_wdata[15:0];
        ftl_pkg::CFG_ROW_PITCH:     cfg_r.pitch  <= cfg_wdata[15:0];
        ftl_pkg::CFG_ROW_STRIDE:    cfg_r.stride <= cfg_wdata[15:0];
        ftl_pkg::CFG_BASE_ADDRESS:  cfg_r.base   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- handshake
  logic busy_r;
  logic accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // ---- stage 0: capture item, ceil dividends, empty-region flag
  logic          s0_vld_r;
  logic          s0_ok_r;
  logic [NW-1:0] s0_num_r;
  logic [SW-1:0] s0_cw_r, s0_ch_r;
  logic [SW:0]   cw_nxt, ch_nxt;

  assign cw_nxt = {1'b0, cfg_r.wid} + {1'b0, cfg_r.side} - (SW+1)'(1);
  assign ch_nxt = {1'b0, cfg_r.hgt} + {1'b0, cfg_r.side} - (SW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_num_r <= in_tile_number;
    s0_ok_r  <= (cfg_r.side != '0) && (cfg_r.wid != '0) && (cfg_r.hgt != '0);
    s0_cw_r  <= cw_nxt[SW-1:0];
    s0_ch_r  <= ch_nxt[SW-1:0];
  end

  // ---- tiles per row and per column (ceil division by the tile side)
  logic          a_cvld, a_rvld;
  logic [SW-1:0] a_cols, a_rows;
  logic [SW-1:0] a_crem_unused_chk, a_rrem_unused_chk;
  logic [NW-1:0] a_num;
  logic          a_ok;

  ftl_div_pipe #(
    .DW(SW), .VW(SW), .QW(SW), .SPS(STEPS), .SW(NW)
  ) u_div_cols (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (s0_vld_r),
    .in_dividend(s0_cw_r),
    .in_divisor (cfg_r.side),
    .in_side    (s0_num_r),
    .out_vld    (a_cvld),
    .out_quo    (a_cols),
    .out_rem    (a_crem_unused_chk),
    .out_side   (a_num)
  );

  ftl_div_pipe #(
    .DW(SW), .VW(SW), .QW(SW), .SPS(STEPS), .SW(1)
  ) u_div_rows (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (s0_vld_r),
    .in_dividend(s0_ch_r),
    .in_divisor (cfg_r.side),
    .in_side    (s0_ok_r),
    .out_vld    (a_rvld),
    .out_quo    (a_rows),
    .out_rem    (a_rrem_unused_chk),
    .out_side   (a_ok)
  );

  // ---- tile count, for the last-row check
  logic          m_vld_r;
  logic          m_ok_r;
  logic [NW-1:0] m_num_r;
  logic [SW-1:0] m_cols_r;
  logic [TW-1:0] m_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= a_cvld;
    end
  end

  always_ff @(posedge clk) begin
    m_ok_r    <= a_ok;
    m_num_r   <= a_num;
    m_cols_r  <= a_cols;
    m_total_r <= {{SW{1'b0}}, a_rows} * {{SW{1'b0}}, a_cols};
  end

  // ---- row and column of the tile: number / cols
  ftl_pkg::loc_side_t b_side_in, b_side_out;
  logic               b_vld;
  logic [SW-1:0]      b_row, b_col;

  always_comb begin
    b_side_in.number  = m_num_r;
    b_side_in.tile_ok = m_ok_r && ({{(TW-NW){1'b0}}, m_num_r} < m_total_r);
  end

  ftl_div_pipe #(
    .DW(NW), .VW(SW), .QW(SW), .SPS(STEPS), .SW(LSW)
  ) u_div_loc (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (m_vld_r),
    .in_dividend(m_num_r),
    .in_divisor (m_cols_r),
    .in_side    (b_side_in),
    .out_vld    (b_vld),
    .out_quo    (b_row),
    .out_rem    (b_col),
    .out_side   (b_side_out)
  );

  // ---- placement and result register
  ftl_pkg::loc_t loc;
  ftl_pkg::res_t res;

  always_comb begin
    loc.vld     = b_vld;
    loc.tile_ok = b_side_out.tile_ok;
    loc.number  = b_side_out.number;
    loc.row     = b_row;
    loc.col     = b_col;
  end

  ftl_place u_place (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .loc       (loc),
    .res_strobe(out_strobe),
    .res       (res)
  );

  assign out_tile_valid   = res.valid;
  assign out_tile_address = res.address;
  assign out_tile_x       = res.x;
  assign out_tile_y       = res.y;
  assign out_tile_width   = res.width;
  assign out_tile_height  = res.height;
  assign out_tile_stride  = res.stride;
  assign out_echo_number  = res.number;

  // ---- checks
  // both side dividers carry the same item in lockstep
  `ASSERT_ALWAYS(a_div_align, clk, rst_n, a_cvld == a_rvld)
  // each side division leaves a remainder below the tile side
  `ASSERT_IMPLY(a_rem_range, clk, rst_n, a_cvld && a_ok,
                (a_crem_unused_chk < cfg_r.side) && (a_rrem_unused_chk < cfg_r.side))
  // every result traces back to an accepted item
  `ASSERT_IMPLY(a_strobe_src, clk, rst_n, out_strobe, $past(accept, PIPE_REGS))
  // a missing tile carries no geometry
  `ASSERT_IMPLY(a_void_zero, clk, rst_n, out_strobe && !out_tile_valid,
                (out_tile_address == '0) && (out_tile_width == '0) && (out_tile_stride == '0))
  // a real tile is never clipped to nothing
  `ASSERT_IMPLY(a_tile_size, clk, rst_n, out_strobe && out_tile_valid,
                (out_tile_width != '0) && (out_tile_height != '0))

endmodule

// ----- dv/fragment_tile_locator_unit_tb.sv -----
// Self-checking testbench for fragment_tile_locator_unit: tile requests are
// checked against a behavioral tile-grid predictor. Depends on ftl_pkg.
`timescale 1ns / 1ps

module fragment_tile_locator_unit_tb;

  localparam int          NUM_REGS     = 8;
  localparam logic [7:0]  ALL_REGS     = 8'hFF;
  localparam int          PIXEL_BYTES  = 4;
  localparam int          SIDE_LIMIT   = 4096;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          REPORT_MAX   = 10;

  // expected contents of one result item
  typedef struct packed {
    logic        valid;
    logic [31:0] address;
    logic [16:0] x;
    logic [16:0] y;
    logic [12:0] width;
    logic [12:0] height;
    logic [16:0] stride;
    logic [23:0] number;
  } tile_result_t;

  // register copy held by the predictor
  typedef struct {
    logic [12:0] side;
    logic [12:0] wid;
    logic [12:0] hgt;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [15:0] pitch;
    logic [15:0] stride;
    logic [31:0] base;
  } region_cfg_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [23:0] in_tile_number = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        out_strobe;
  logic        out_tile_valid;
  logic [31:0] out_tile_address;
  logic [16:0] out_tile_x;
  logic [16:0] out_tile_y;
  logic [12:0] out_tile_width;
  logic [12:0] out_tile_height;
  logic [16:0] out_tile_stride;
  logic [23:0] out_echo_number;

  region_cfg_t  region;
  logic [31:0]  reg_image [NUM_REGS];
  tile_result_t pending_tiles [$];
  int           mismatches = 0;
  int           stall_cycles = 0;

  fragment_tile_locator_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_tile_number   (in_tile_number),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .out_strobe       (out_strobe),
    .out_tile_valid   (out_tile_valid),
    .out_tile_address (out_tile_address),
    .out_tile_x       (out_tile_x),
    .out_tile_y       (out_tile_y),
    .out_tile_width   (out_tile_width),
    .out_tile_height  (out_tile_height),
    .out_tile_stride  (out_tile_stride),
    .out_echo_number  (out_echo_number)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned limit_side(logic [12:0] v);
    return (v > SIDE_LIMIT) ? SIDE_LIMIT : v;
  endfunction

  // clamped sides and tile grid dimensions for the current registers
  function automatic void grid_dims(output longint unsigned side, wid, hgt, cols, rows);
    side = limit_side(region.side);
    wid  = limit_side(region.wid);
    hgt  = limit_side(region.hgt);
    cols = 0;
    rows = 0;
    if (side != 0) begin
      cols = (wid + side - 1) / side;
      rows = (hgt + side - 1) / side;
    end
  endfunction

  function automatic tile_result_t locate_tile(logic [23:0] number);
    tile_result_t r;
    longint unsigned side, wid, hgt, cols, rows, row, col, xoff, yoff, tw, th;
    r = '0;
    r.number = number;
    grid_dims(side, wid, hgt, cols, rows);
    if (cols == 0 || rows == 0) return r;
    row = number / cols;
    // past the last row: only the number comes back
    if (row >= rows) return r;
    col  = number - row * cols;
    xoff = col * side;
    yoff = row * side;
    tw   = wid - xoff;
    if (tw > side) tw = side;
    th   = hgt - yoff;
    if (th > side) th = side;
    r.valid   = 1'b1;
    r.address = 32'(region.base + yoff * region.pitch + xoff * PIXEL_BYTES);
    r.x       = 17'(region.rx + xoff);
    r.y       = 17'(region.ry + yoff);
    r.width   = 13'(tw);
    r.height  = 13'(th);
    r.stride  = 17'(region.stride + (wid - tw) * PIXEL_BYTES);
    return r;
  endfunction

  function automatic void region_write(ftl_pkg::cfg_idx_t idx, logic [31:0] v);
    case (idx)
      ftl_pkg::CFG_TILE_SIZE:     region.side   = v[12:0];
      ftl_pkg::CFG_REGION_WIDTH:  region.wid    = v[12:0];
      ftl_pkg::CFG_REGION_HEIGHT: region.hgt    = v[12:0];
      ftl_pkg::CFG_REGION_X:      region.rx     = v[15:0];
      ftl_pkg::CFG_REGION_Y:      region.ry     = v[15:0];
      ftl_pkg::CFG_ROW_PITCH:     region.pitch  = v[15:0];
      ftl_pkg::CFG_ROW_STRIDE:    region.stride = v[15:0];
      ftl_pkg::CFG_BASE_ADDRESS:  region.base   = v;
      default: ;
    endcase
  endfunction

  function automatic void region_reset();
    region.side   = 13'd64;
    region.wid    = '0;
    region.hgt    = '0;
    region.rx     = '0;
    region.ry     = '0;
    region.pitch  = '0;
    region.stride = '0;
    region.base   = '0;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < REPORT_MAX)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tile_result_t want;
    if (rst_n && out_strobe) begin
      if (pending_tiles.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: result with no pending request, number %h", $realtime,
                   out_echo_number);
        mismatches++;
      end else begin
        want = pending_tiles.pop_front();
        check_field("tile_valid",   want.valid,   out_tile_valid);
        check_field("tile_address", want.address, out_tile_address);
        check_field("tile_x",       want.x,       out_tile_x);
        check_field("tile_y",       want.y,       out_tile_y);
        check_field("tile_width",   want.width,   out_tile_width);
        check_field("tile_height",  want.height,  out_tile_height);
        check_field("tile_stride",  want.stride,  out_tile_stride);
        check_field("echo_number",  want.number,  out_echo_number);
      end
    end
  end

  // watchdog: cycles without any item moving on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- drivers

  // hold off until every request has been answered
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_tiles.size() != 0);
  endtask

  // write the selected entries of reg_image, block idle
  task automatic program_regs(logic [7:0] sel);
    wait_drained();
    for (int i = 0; i < NUM_REGS; i++) begin
      if (sel[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= ftl_pkg::cfg_idx_t'(i);
        cfg_wdata <= reg_image[i];
        @(posedge clk);
        region_write(ftl_pkg::cfg_idx_t'(i), reg_image[i]);
      end
    end
    cfg_we <= 1'b0;
  endtask

  task automatic set_image(logic [31:0] side, wid, hgt, rx, ry, pitch, stride, base);
    reg_image[ftl_pkg::CFG_TILE_SIZE]     = side;
    reg_image[ftl_pkg::CFG_REGION_WIDTH]  = wid;
    reg_image[ftl_pkg::CFG_REGION_HEIGHT] = hgt;
    reg_image[ftl_pkg::CFG_REGION_X]      = rx;
    reg_image[ftl_pkg::CFG_REGION_Y]      = ry;
    reg_image[ftl_pkg::CFG_ROW_PITCH]     = pitch;
    reg_image[ftl_pkg::CFG_ROW_STRIDE]    = stride;
    reg_image[ftl_pkg::CFG_BASE_ADDRESS]  = base;
  endtask

  // one tile request; start is left high for a following item
  task automatic send_tile(logic [23:0] number, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_tile_number <= number;
    do @(posedge clk); while (busy);
    pending_tiles.push_back(locate_tile(number));
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_side();
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return 1;
      2:       return SIDE_LIMIT;
      3:       return $urandom_range(SIDE_LIMIT + 1, 8191);
      4, 5, 6: return $urandom_range(1, 16);
      7, 8:    return $urandom_range(17, 300);
      default: return $urandom_range(1, SIDE_LIMIT);
    endcase
  endfunction

  function automatic logic [31:0] rand_word16();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 32'h0000_FFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  // sometimes set the bits above a register's width
  function automatic logic [31:0] with_junk(logic [31:0] v, int w);
    if ($urandom_range(0, 3) == 0) return v | (($urandom >> w) << w);
    return v;
  endfunction

  // ---------------------------------------------------------------- tests

  // reset values: empty region, then tile size 64 left at its reset value
  task automatic test_reset_values();
    send_tile(24'h000000, 0);
    send_tile(24'hFFFFFF, 0);
    reg_image[ftl_pkg::CFG_REGION_WIDTH]  = 200;
    reg_image[ftl_pkg::CFG_REGION_HEIGHT] = 130;
    program_regs((8'd1 << ftl_pkg::CFG_REGION_WIDTH) |
                 (8'd1 << ftl_pkg::CFG_REGION_HEIGHT));
    send_tile(24'd0, 0);
    send_tile(24'd3, 1);
    send_tile(24'd11, 0);
    send_tile(24'd12, 0);
  endtask

  // widest grid and all-ones placement registers: address wraps
  task automatic test_field_extremes();
    set_image(1, SIDE_LIMIT, SIDE_LIMIT, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF,
              32'hFFFF_FFFF);
    program_regs(ALL_REGS);
    send_tile(24'h000000, 0);
    send_tile(24'hFFFFFF, 0);
    send_tile(24'h555555, 0);
    send_tile(24'hAAAAAA, 2);
    send_tile(24'd4095, 0);
    send_tile(24'd4096, 0);
  endtask

  // oversized side registers are clamped: one tile covers the region
  task automatic test_oversize_clamp();
    set_image(8191, 8191, 5000, 32'h1234, 32'h0042, 32'h4000, 32'h0010, 32'h8000_0000);
    program_regs(ALL_REGS);
    send_tile(24'd0, 0);
    send_tile(24'd1, 0);
  endtask

  // zero tile size, zero width, zero height: nothing exists
  task automatic test_empty_regions();
    set_image(0, 100, 100, 5, 6, 400, 8, 32'h1000);
    program_regs(ALL_REGS);
    send_tile(24'd0, 0);
    set_image(16, 0, 100, 5, 6, 400, 8, 32'h1000);
    program_regs(ALL_REGS);
    send_tile(24'd0, 0);
    set_image(16, 100, 0, 5, 6, 400, 8, 32'h1000);
    program_regs(ALL_REGS);
    send_tile(24'd0, 0);
  endtask

  // partial tiles at the right and bottom edges are clipped
  task automatic test_edge_clipping();
    set_image(3, 10, 7, 100, 200, 40, 12, 32'h0000_2000);
    program_regs(ALL_REGS);
    send_tile(24'd3, 0);
    send_tile(24'd8, 0);
    send_tile(24'd11, 0);
    send_tile(24'd12, 0);
  endtask

  // random regions, mostly in-grid tile numbers, random pacing
  task automatic test_random_regions();
    longint unsigned side, wid, hgt, cols, rows, total;
    logic [23:0] number;
    bit          full_rate;
    int          r;
    for (int phase = 0; phase < 25; phase++) begin
      set_image(with_junk(rand_side(), 13), with_junk(rand_side(), 13),
                with_junk(rand_side(), 13), with_junk(rand_word16(), 16),
                with_junk(rand_word16(), 16), with_junk(rand_word16(), 16),
                with_junk(rand_word16(), 16), $urandom);
      program_regs(ALL_REGS);
      grid_dims(side, wid, hgt, cols, rows);
      total = cols * rows;
      full_rate = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 30; k++) begin
        r = $urandom_range(0, 9);
        if (total != 0 && r < 8) number = 24'($urandom_range(0, 32'(total - 1)));
        else if (r == 8)         number = 24'(total + $urandom_range(0, 7));
        else                     number = 24'($urandom);
        send_tile(number, full_rate ? 0 : pick_gap());
        // let the pipeline run dry now and then
        if ((phase == 3 && k == 15) || $urandom_range(0, 99) == 0) wait_drained();
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    region_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_field_extremes();
    test_oversize_clamp();
    test_empty_regions();
    test_edge_clipping();
    test_random_regions();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_tiles.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
